### hw/rtl/apu_pkg.sv
// ----------------------------------------------------------------------------
// apu_pkg: shared types and constants of the alpha premultiply block
// Holds the sample format, the register file layout and the item record
// that walks down the row of division cells.
// ----------------------------------------------------------------------------
package apu_pkg;

	localparam int SAMPLE_BITS       = 8;
	localparam int SAMPLES_PER_PIXEL = 4;
	localparam int NUM_SLOTS         = 4;
	localparam int SLOT_BITS         = 2;
	localparam int NUM_CELLS         = SAMPLE_BITS;
	localparam int CFG_DATA_BITS     = 4;

	localparam logic [SAMPLE_BITS-1:0] MAXV = {SAMPLE_BITS{1'b1}};

	// Values of the mode register.
	localparam logic MODE_PREMUL   = 1'b0;
	localparam logic MODE_UNPREMUL = 1'b1;

	typedef enum logic [1:0] {
		CFG_MODE       = 2'd0,
		CFG_HAS_ALPHA  = 2'd1,
		CFG_ALPHA_SLOT = 2'd2,
		CFG_COLOR_MASK = 2'd3
	} cfg_reg_e;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic                 mode;
		logic                 has_alpha;
		logic [SLOT_BITS-1:0] alpha_slot;
		logic [NUM_SLOTS-1:0] color_mask;
	} cfg_t;

	// One slot in flight: partial remainder, dividend bits still to shift
	// in (quotient bits fill from the bottom), the original sample and flags.
	typedef struct packed {
		sample_t rem;
		sample_t work;
		sample_t orig;
		logic    sel;
		logic    sat;
	} lane_t;

	typedef struct packed {
		lane_t [NUM_SLOTS-1:0] lane;
		sample_t               divisor;
		logic                  zero;
		logic                  row_end;
	} item_t;

endpackage

### hw/rtl/apu_front.sv
// ----------------------------------------------------------------------------
// apu_front: alpha selection and numerator multiply
// Picks alpha, forms the dividend and divisor for every slot and flags
// slots whose quotient would overflow full scale.
// ----------------------------------------------------------------------------
module apu_front
	import apu_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  sample_t [NUM_SLOTS-1:0]        in_sample,
	input  logic                           in_row_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output item_t                          out_item
);

	logic    valid_s1;
	item_t   item_s1;
	item_t   item_d;
	sample_t alpha;
	sample_t mult;
	logic    zero;

	assign alpha = cfg.has_alpha ? in_sample[cfg.alpha_slot] : MAXV;
	assign zero  = (cfg.mode == MODE_UNPREMUL) && (alpha == '0);
	// Premultiply divides s*alpha by full scale; unpremultiply divides
	// s*full scale by alpha.
	assign mult  = (cfg.mode == MODE_UNPREMUL) ? MAXV : alpha;

	always_comb begin
		logic [2*SAMPLE_BITS-1:0] prod;
		item_d.divisor = (cfg.mode == MODE_UNPREMUL) ? alpha : MAXV;
		item_d.zero    = zero;
		item_d.row_end = in_row_end;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			prod = {{SAMPLE_BITS{1'b0}}, in_sample[k]} * {{SAMPLE_BITS{1'b0}}, mult};
			item_d.lane[k].rem  = prod[2*SAMPLE_BITS-1:SAMPLE_BITS];
			item_d.lane[k].work = prod[SAMPLE_BITS-1:0];
			item_d.lane[k].orig = in_sample[k];
			item_d.lane[k].sel  = (k < SAMPLES_PER_PIXEL) && cfg.color_mask[k];
			// The quotient reaches 2^SAMPLE_BITS exactly when the high half
			// of the dividend is not below the divisor.
			item_d.lane[k].sat  = item_d.lane[k].sel && !zero &&
				(prod[2*SAMPLE_BITS-1:SAMPLE_BITS] >= item_d.divisor);
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

### hw/rtl/apu_cell.sv
// ----------------------------------------------------------------------------
// apu_cell: one restoring division step for every slot
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the resulting quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module apu_cell
	import apu_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item
);

	logic  valid_q;
	item_t item_q;
	item_t item_d;

	always_comb begin
		logic [SAMPLE_BITS:0] r2;
		logic [SAMPLE_BITS:0] diff;
		logic                 ge;
		item_d = in_item;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			r2   = {in_item.lane[k].rem, in_item.lane[k].work[SAMPLE_BITS-1]};
			diff = r2 - {1'b0, in_item.divisor};
			ge   = (r2 >= {1'b0, in_item.divisor});
			item_d.lane[k].rem  = ge ? diff[SAMPLE_BITS-1:0] : r2[SAMPLE_BITS-1:0];
			item_d.lane[k].work = {in_item.lane[k].work[SAMPLE_BITS-2:0], ge};
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= item_d;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

### hw/rtl/alpha_premultiply_unpremultiply.sv
// ----------------------------------------------------------------------------
// alpha_premultiply_unpremultiply: streaming alpha premultiply / unpremultiply
// The pipeline is one multiply stage, one division cell per quotient bit
// and the output register. Throughput is one pixel per cycle while
// m_axis_tready stays high; every stage holds its own item and an
// empty stage takes a new one even while the stage behind it is stalled.
// Reset clears all valid bits and loads the register defaults; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module alpha_premultiply_unpremultiply
	import apu_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	// Input pixels.
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// sample0 [7:0], sample1 [15:8], sample2 [23:16], sample3 [31:24]
	input  logic [NUM_SLOTS*SAMPLE_BITS-1:0] s_axis_tdata,
	input  logic                           s_axis_tlast,   // row_end
	// Result pixels.
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// out_sample0 [7:0], out_sample1 [15:8], out_sample2 [23:16], out_sample3 [31:24]
	output logic [NUM_SLOTS*SAMPLE_BITS-1:0] m_axis_tdata,
	// saturated [0], zero_alpha [1]
	output logic [1:0]                     m_axis_tuser,
	output logic                           m_axis_tlast,   // row_end_out
	// Register writes.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]       cfg_data
);

	// ------------------------------------------------------------------
	// Register file. Writes are expected only while no pixel is in flight,
	// so the settings are used directly by the front stage.
	// ------------------------------------------------------------------
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= MODE_PREMUL;
			cfg_q.has_alpha  <= 1'b1;
			cfg_q.alpha_slot <= 2'd3;
			cfg_q.color_mask <= 4'd7;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				CFG_MODE:       cfg_q.mode       <= cfg_data[0];
				CFG_HAS_ALPHA:  cfg_q.has_alpha  <= cfg_data[0];
				CFG_ALPHA_SLOT: cfg_q.alpha_slot <= cfg_data[SLOT_BITS-1:0];
				CFG_COLOR_MASK: cfg_q.color_mask <= cfg_data[NUM_SLOTS-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Front stage: alpha selection, multiply and overflow detection.
	// Both operations become one division: premultiply divides
	// sample*alpha by full scale, unpremultiply divides sample*full scale
	// by alpha.
	// ------------------------------------------------------------------
	sample_t [NUM_SLOTS-1:0] in_sample;

	always_comb begin
		for (int k = 0; k < NUM_SLOTS; k++) begin
			in_sample[k] = s_axis_tdata[k*SAMPLE_BITS +: SAMPLE_BITS];
		end
	end

	logic  [NUM_CELLS:0] valid_c;
	logic  [NUM_CELLS:0] ready_c;
	item_t [NUM_CELLS:0] item_c;

	apu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_sample  (in_sample),
		.in_row_end (s_axis_tlast),
		.out_valid  (valid_c[0]),
		.out_ready  (ready_c[0]),
		.out_item   (item_c[0])
	);

	// ------------------------------------------------------------------
	// Row of division cells. Slots that would overflow were flagged up
	// front, so the quotient fits in SAMPLE_BITS and each cell produces
	// one quotient bit, most significant first.
	// ------------------------------------------------------------------
	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		apu_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[c]),
			.in_ready  (ready_c[c]),
			.in_item   (item_c[c]),
			.out_valid (valid_c[c+1]),
			.out_ready (ready_c[c+1]),
			.out_item  (item_c[c+1])
		);
	end

	// ------------------------------------------------------------------
	// Output register: selects the quotient, the clamp value, zero or
	// the untouched sample for each slot and merges the flags.
	// ------------------------------------------------------------------
	item_t                           last;
	logic                            out_valid_q;
	logic [NUM_SLOTS*SAMPLE_BITS-1:0] out_data_q;
	logic [1:0]                      out_user_q;
	logic                            out_last_q;
	logic [NUM_SLOTS*SAMPLE_BITS-1:0] fmt_data;
	logic                            fmt_sat;

	assign last = item_c[NUM_CELLS];

	always_comb begin
		fmt_sat = 1'b0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (!last.lane[k].sel) begin
				fmt_data[k*SAMPLE_BITS +: SAMPLE_BITS] = last.lane[k].orig;
			end else if (last.zero) begin
				fmt_data[k*SAMPLE_BITS +: SAMPLE_BITS] = '0;
			end else if (last.lane[k].sat) begin
				fmt_data[k*SAMPLE_BITS +: SAMPLE_BITS] = MAXV;
			end else begin
				fmt_data[k*SAMPLE_BITS +: SAMPLE_BITS] = last.lane[k].work;
			end
			fmt_sat = fmt_sat | last.lane[k].sat;
		end
	end

	assign ready_c[NUM_CELLS] = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_c[NUM_CELLS]) begin
			out_valid_q <= valid_c[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_c[NUM_CELLS] && valid_c[NUM_CELLS]) begin
			out_data_q <= fmt_data;
			out_user_q <= {last.zero, fmt_sat};
			out_last_q <= last.row_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// A zero alpha result never also reports a clamped color.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("zero_alpha and saturated reported together");

	// The zero flag travels only with a zero divisor.
	a_zero_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_c[NUM_CELLS] && last.zero) |-> (last.divisor == '0))
		else $error("zero flag with nonzero divisor");

	// An empty output register never holds back the cell row.
	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> ready_c[NUM_CELLS])
		else $error("cell row stalled behind empty output register");

endmodule
